[sv/mrfb_pkg.sv]
`timescale 1ns / 1ps
package mrfb_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_BYTES = 8;
    localparam int BODY_BYTES  = 6;
    localparam int BODY_W      = BODY_BYTES * BYTE_W;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] CNT_CRC_LO = CNT_W'(BODY_BYTES);
    localparam logic [CNT_W-1:0] CNT_CRC_HI = CNT_W'(FRAME_BYTES - 1);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] READ_QUANTITY     = 16'h0001;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR   = 2'd1;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h01;
    localparam logic [15:0] REG_ADDR_RESET   = 16'h0001;

    typedef logic [BODY_W-1:0] body_t;

    // one byte through the reflected crc-16, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] acc_in,
                                             input logic [7:0] data);
        logic [15:0] acc;
        acc = acc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

endpackage

[sv/mrfb_frame.sv]
`timescale 1ns / 1ps
module mrfb_frame (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_kind,
    input  logic [15:0]           in_value,
    input  logic [7:0]            slave_addr,
    input  logic [15:0]           reg_addr,
    output logic                  body_valid,
    input  logic                  body_ready,
    output mrfb_pkg::body_t       body
);
    import mrfb_pkg::*;

    logic        body_valid_reg;
    logic        body_valid_next;
    body_t       body_reg;
    body_t       body_next;
    logic [7:0]  func;
    logic [15:0] payload;
    logic        load;

    assign in_ready = !body_valid_reg || body_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        func    = (in_kind == KIND_READ) ? FUNC_READ_HOLDING : FUNC_WRITE_SINGLE;
        payload = (in_kind == KIND_READ) ? READ_QUANTITY : in_value;
        // transmit order from the low byte up
        body_next = {payload[7:0], payload[15:8], reg_addr[7:0], reg_addr[15:8],
                     func, slave_addr};
        body_valid_next = body_valid_reg;
        if (load)
            body_valid_next = 1'b1;
        else if (body_ready)
            body_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            body_valid_reg <= 1'b0;
        else
            body_valid_reg <= body_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            body_reg <= body_next;
    end

    assign body_valid = body_valid_reg;
    assign body       = body_reg;

endmodule

[sv/mrfb_serializer.sv]
`timescale 1ns / 1ps
module mrfb_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  body_valid,
    output logic                  body_ready,
    input  mrfb_pkg::body_t       body,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);
    import mrfb_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    body_t            shift_reg, shift_next;
    logic [15:0]      crc_reg, crc_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             adv;
    logic             emit;
    logic             load;

    assign adv        = !valid_reg || out_ready;
    assign emit       = busy_reg && adv;
    assign body_ready = !busy_reg || (emit && cnt_reg == CNT_CRC_HI);
    assign load       = body_valid && body_ready;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        crc_next   = crc_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;

        if (adv)
            valid_next = 1'b0;

        if (emit)
        begin
            valid_next = 1'b1;
            cnt_next   = cnt_reg + 1'b1;
            last_next  = 1'b0;
            if (cnt_reg == CNT_CRC_HI)
            begin
                byte_next = crc_reg[15:8];
                last_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (cnt_reg == CNT_CRC_LO)
            begin
                byte_next = crc_reg[7:0];
            end
            else
            begin
                // body bytes: checksum follows what goes out
                byte_next  = shift_reg[7:0];
                crc_next   = crc_byte(crc_reg, shift_reg[7:0]);
                shift_next = shift_reg >> BYTE_W;
            end
        end

        if (load)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = body;
            crc_next   = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        crc_reg   <= crc_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

[sv/modbus_request_frame_builder.sv]
`timescale 1ns / 1ps
// Builds one 8-byte Modbus RTU request frame per input beat and sends it out one
// byte per beat: slave address, function code (6 for a write with tuser 0, 3 for a
// read with tuser 1), register address high and low, payload high and low (the
// write value, or a quantity of one for reads), then the crc-16 low and high byte,
// with tlast on the crc high byte. Slave address (index 0) and register address
// (index 1) are set over the cfg port and sampled when a request is taken, so
// write them only while no frame is in flight. A frame takes eight output beats;
// the byte serializer sets the rate, and the input register takes the next
// request while the current frame is still going out. A request passes the frame
// body register, the serializer shift register and the output byte register.
module modbus_request_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // value[15:0]
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // frame_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mrfb_pkg::*;

    logic [7:0]  slave_addr_reg, slave_addr_next;
    logic [15:0] reg_addr_reg, reg_addr_next;
    logic        body_valid;
    logic        body_ready;
    body_t       body;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        slave_addr_next = slave_addr_reg;
        reg_addr_next   = reg_addr_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLAVE_ADDR: slave_addr_next = cfg_data[7:0];
                CFG_REG_ADDR:   reg_addr_next   = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            reg_addr_reg   <= REG_ADDR_RESET;
        end
        else
        begin
            slave_addr_reg <= slave_addr_next;
            reg_addr_reg   <= reg_addr_next;
        end
    end

    mrfb_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_value   (s_tdata),
        .slave_addr (slave_addr_reg),
        .reg_addr   (reg_addr_reg),
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body       (body)
    );

    mrfb_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body       (body),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
